[rtl/rbfe_pkg.sv]
// Shared types, codes and helper functions for the rectangle blit unit.
package rbfe_pkg;

	// Request type codes
	localparam logic REQ_CMD   = 1'b0;
	localparam logic REQ_PIXEL = 1'b1;

	// Configuration register indexes
	localparam int  CFG_IDX_W    = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_FB_BASE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FB_WIDTH = 1'b1;

	localparam logic [12:0] FB_WIDTH_RESET = 13'd640;

	// Bytes per pixel
	localparam logic [2:0] BPP_1 = 3'd1;
	localparam logic [2:0] BPP_3 = 3'd3;
	localparam logic [2:0] BPP_4 = 3'd4;

	// Format code to bytes per pixel: code 0 gives one byte, codes 1 and 5 three, all others four
	localparam logic [2:0] FMT_BYTES [8] = '{BPP_1, BPP_3, BPP_4, BPP_4,
		BPP_4, BPP_3, BPP_4, BPP_4};

	localparam logic [24:0] PIXEL_TOTAL_MAX = 25'h1FF_FFFF;

	// Front-to-back queue size
	localparam int QPTR_W = 1;
	localparam int QDEPTH = 1 << QPTR_W;

	typedef enum logic [1:0] {
		KIND_ACK   = 2'd0,
		KIND_PIXEL = 2'd1,
		KIND_STRAY = 2'd2
	} kind_t;

	typedef struct packed {
		logic [31:0] fb_base;
		logic [12:0] fb_width;
	} rbfe_cfg_t;

	// One classified word handed from front to back
	typedef struct packed {
		kind_t       kind;
		logic        last;
		logic [12:0] off_row;   // source coordinate of the next fetch
		logic [12:0] off_col;
		logic [12:0] stride;
		logic [2:0]  bpp;
		logic [13:0] dst_row;   // destination coordinate of this write
		logic [13:0] dst_col;
		logic [12:0] ext_w;     // clipped window size, ack only
		logic [12:0] ext_h;
		logic [31:0] word;      // widened pixel
	} rbfe_job_t;

	// Repeat the last source byte into the missing upper bytes
	function automatic logic [31:0] widen(input logic [31:0] bytes, input logic [2:0] size);
		logic [31:0] w;
		case (size)
			BPP_1:   w = {4{bytes[7:0]}};
			BPP_3:   w = {bytes[23:16], bytes[23:0]};
			default: w = bytes;
		endcase
		return w;
	endfunction

endpackage

[rtl/rbfe_if.sv]
// Channel interfaces: request, response and configuration write.
interface rbfe_in_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [11:0] src_x;
	logic [11:0] src_y;
	logic [12:0] src_width;
	logic [12:0] src_height;
	logic [2:0]  src_format;
	logic [11:0] dst_x;
	logic [11:0] dst_y;
	logic [12:0] copy_width;
	logic [12:0] copy_height;
	logic [31:0] pixel_bytes;

	modport source (output valid, req_type, src_x, src_y, src_width, src_height, src_format,
		dst_x, dst_y, copy_width, copy_height, pixel_bytes, input ready);
	modport sink (input valid, req_type, src_x, src_y, src_width, src_height, src_format,
		dst_x, dst_y, copy_width, copy_height, pixel_bytes, output ready);
endinterface

interface rbfe_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] dst_addr;
	logic [31:0] dst_word;
	logic [25:0] next_src_offset;
	logic [24:0] pixel_total;
	logic        last;

	modport source (output valid, kind, dst_addr, dst_word, next_src_offset, pixel_total,
		last, input ready);
	modport sink (input valid, kind, dst_addr, dst_word, next_src_offset, pixel_total,
		last, output ready);
endinterface

interface rbfe_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/rbfe_front.sv]
// Front end: accepts words, clips commands, walks the window and classifies pixels.
module rbfe_front #(
	parameter int MAX_DIM = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	rbfe_in_if.sink           req,
	output logic              job_valid,
	input  logic              job_ready,
	output rbfe_pkg::rbfe_job_t job
);
	import rbfe_pkg::*;

	localparam logic [31:0] MaxDimU = 32'(MAX_DIM);

	function automatic logic [12:0] clamp_dim(input logic [12:0] v);
		return (32'(v) > MaxDimU) ? MaxDimU[12:0] : v;
	endfunction

	logic        busy_q;
	logic [12:0] cur_col_q, cur_row_q;
	logic [11:0] start_col_q, start_row_q;
	logic [12:0] end_col_q, end_row_q;
	logic [12:0] stride_q;
	logic [2:0]  bpp_q;
	logic [11:0] dest_col_q, dest_row_q;

	logic        accept, is_cmd;
	logic [12:0] sw, sh, cw, ch;
	logic [13:0] ex_sum, ey_sum;
	logic [12:0] ex, ey;
	logic        empty;
	logic [13:0] col_nx, row_nx;
	logic        wrap, fin;
	logic [12:0] new_col, new_row;
	logic [12:0] rel_col, rel_row;

	assign req.ready = job_ready;
	assign job_valid = req.valid;
	assign accept    = req.valid && job_ready;
	assign is_cmd    = (req.req_type == REQ_CMD);

	// command clipping, exclusive bounds
	assign sw     = clamp_dim(req.src_width);
	assign sh     = clamp_dim(req.src_height);
	assign cw     = clamp_dim(req.copy_width);
	assign ch     = clamp_dim(req.copy_height);
	assign ex_sum = 14'(req.src_x) + 14'(cw);
	assign ey_sum = 14'(req.src_y) + 14'(ch);
	assign ex     = (ex_sum > 14'(sw)) ? sw : ex_sum[12:0];
	assign ey     = (ey_sum > 14'(sh)) ? sh : ey_sum[12:0];
	assign empty  = (ex <= 13'(req.src_x)) || (ey <= 13'(req.src_y));

	// raster step
	assign col_nx  = 14'(cur_col_q) + 14'd1;
	assign row_nx  = 14'(cur_row_q) + 14'd1;
	assign wrap    = (col_nx >= 14'(end_col_q));
	assign fin     = wrap && (row_nx >= 14'(end_row_q));
	assign new_col = wrap ? 13'(start_col_q) : col_nx[12:0];
	assign new_row = wrap ? row_nx[12:0] : cur_row_q;
	assign rel_col = cur_col_q - 13'(start_col_q);
	assign rel_row = cur_row_q - 13'(start_row_q);

	always_comb begin
		job = '0;
		if (is_cmd) begin
			job.kind   = KIND_ACK;
			job.last   = empty;
			job.stride = sw;
			job.bpp    = FMT_BYTES[req.src_format];
			if (!empty) begin
				job.off_row = 13'(req.src_y);
				job.off_col = 13'(req.src_x);
				job.ext_w   = ex - 13'(req.src_x);
				job.ext_h   = ey - 13'(req.src_y);
			end
		end else if (busy_q) begin
			job.kind    = KIND_PIXEL;
			job.last    = fin;
			job.stride  = stride_q;
			job.bpp     = bpp_q;
			job.off_row = fin ? '0 : new_row;
			job.off_col = fin ? '0 : new_col;
			job.dst_row = 14'(dest_row_q) + 14'(rel_row);
			job.dst_col = 14'(dest_col_q) + 14'(rel_col);
			job.word    = widen(req.pixel_bytes, bpp_q);
		end else begin
			job.kind = KIND_STRAY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			start_col_q <= '0;
			start_row_q <= '0;
			end_col_q   <= '0;
			end_row_q   <= '0;
			stride_q    <= '0;
			bpp_q       <= BPP_1;
			dest_col_q  <= '0;
			dest_row_q  <= '0;
		end else if (accept) begin
			if (is_cmd) begin
				busy_q      <= !empty;
				start_col_q <= req.src_x;
				start_row_q <= req.src_y;
				cur_col_q   <= 13'(req.src_x);
				cur_row_q   <= 13'(req.src_y);
				end_col_q   <= ex;
				end_row_q   <= ey;
				stride_q    <= sw;
				bpp_q       <= FMT_BYTES[req.src_format];
				dest_col_q  <= req.dst_x;
				dest_row_q  <= req.dst_y;
			end else if (busy_q) begin
				cur_col_q <= new_col;
				cur_row_q <= new_row;
				if (fin) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	a_busy_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cur_col_q < end_col_q) && (cur_row_q < end_row_q))
		else $error("cursor outside the active window");

	a_fin_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_cmd && busy_q && fin) |=> !busy_q)
		else $error("blit still busy after its final pixel");

endmodule

[rtl/rbfe_queue.sv]
// Short queue decoupling the front end from the address back end.
module rbfe_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  rbfe_pkg::rbfe_job_t push_job,
	output logic                pop_valid,
	input  logic                pop_ready,
	output rbfe_pkg::rbfe_job_t pop_job
);
	import rbfe_pkg::*;

	rbfe_job_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]    cnt_q;
	logic               push, pop;

	assign push_ready = (cnt_q != (QPTR_W + 1)'(QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
		end
	end

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> cnt_q == $past(cnt_q) + (QPTR_W + 1)'($past(push))
			- (QPTR_W + 1)'($past(pop)))
		else $error("queue count out of step with push and pop");

endmodule

[rtl/rbfe_back.sv]
// Back end: two-stage address, offset and total computation with output register.
module rbfe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rbfe_pkg::rbfe_cfg_t cfg_regs,
	input  logic                job_valid,
	output logic                job_ready,
	input  rbfe_pkg::rbfe_job_t job,
	rbfe_out_if.source          rsp
);
	import rbfe_pkg::*;

	logic        adv_s1, adv_s2;

	// stage 1: products
	logic        v_s1;
	kind_t       kind_s1;
	logic        last_s1;
	logic [25:0] p_src_s1;
	logic [12:0] off_col_s1;
	logic [2:0]  bpp_s1;
	logic [26:0] p_dst_s1;
	logic [13:0] dst_col_s1;
	logic [25:0] p_tot_s1;
	logic [31:0] word_s1;

	// stage 2: output register
	logic        v_s2;
	kind_t       kind_s2;
	logic        last_s2;
	logic [31:0] dst_addr_s2;
	logic [31:0] dst_word_s2;
	logic [25:0] next_src_offset_s2;
	logic [24:0] pixel_total_s2;

	logic [25:0] src_lin, src_off;
	logic [27:0] dst_lin;
	logic [31:0] addr;
	logic [24:0] tot;

	assign adv_s2    = !v_s2 || rsp.ready;
	assign adv_s1    = !v_s1 || adv_s2;
	assign job_ready = adv_s1;

	always_ff @(posedge clk) begin
		if (adv_s1 && job_valid) begin
			kind_s1    <= job.kind;
			last_s1    <= job.last;
			p_src_s1   <= 26'(job.off_row) * 26'(job.stride);
			off_col_s1 <= job.off_col;
			bpp_s1     <= job.bpp;
			p_dst_s1   <= 27'(job.dst_row) * 27'(cfg_regs.fb_width);
			dst_col_s1 <= job.dst_col;
			p_tot_s1   <= 26'(job.ext_w) * 26'(job.ext_h);
			word_s1    <= job.word;
		end
	end

	// linear offsets; the source offset scales by bytes per pixel (1, 3 or 4), the destination by four
	assign src_lin = p_src_s1 + 26'(off_col_s1);
	always_comb begin
		case (bpp_s1)
			BPP_1:   src_off = src_lin;
			BPP_3:   src_off = src_lin + {src_lin[24:0], 1'b0};
			default: src_off = {src_lin[23:0], 2'b00};
		endcase
	end
	assign dst_lin = 28'(p_dst_s1) + 28'(dst_col_s1);
	assign addr    = cfg_regs.fb_base + {2'b00, dst_lin, 2'b00};
	assign tot     = (p_tot_s1 > {1'b0, PIXEL_TOTAL_MAX}) ? PIXEL_TOTAL_MAX : p_tot_s1[24:0];

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			kind_s2            <= kind_s1;
			last_s2            <= last_s1;
			dst_addr_s2        <= (kind_s1 == KIND_PIXEL) ? addr : '0;
			dst_word_s2        <= word_s1;
			next_src_offset_s2 <= src_off;
			pixel_total_s2     <= tot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= job_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	assign rsp.valid           = v_s2;
	assign rsp.kind            = kind_s2;
	assign rsp.last            = last_s2;
	assign rsp.dst_addr        = dst_addr_s2;
	assign rsp.dst_word        = dst_word_s2;
	assign rsp.next_src_offset = next_src_offset_s2;
	assign rsp.pixel_total     = pixel_total_s2;

	a_nonpixel_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && kind_s2 != KIND_PIXEL) |-> (dst_addr_s2 == '0) && (dst_word_s2 == '0))
		else $error("non-pixel word carries a write address or data");

	a_stray_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && kind_s2 == KIND_STRAY) |->
			(next_src_offset_s2 == '0) && (pixel_total_s2 == '0) && !last_s2)
		else $error("stray pixel word has nonzero fields");

endmodule

[rtl/rect_blit_format_expand_unit.sv]
// Top level of the 2D rectangle blit unit with format expansion.
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+---------------------------------------------
//  cfg     | in  | valid/ready | index (0 fb_base, 1 fb_width), data
//  req     | in  | valid/ready | command (window, sizes, format, dest) or pixel
//  rsp     | out | valid/ready | kind, dst_addr, dst_word, next_src_offset,
//          |     |             | pixel_total, last
//
// Cycles: one req word per clock while rsp.ready is high, one rsp word per
//   req word. A request passes the queue, the stage-1 and output registers;
//   the rate is set by the front end's one-step raster counters and the back
//   end's stage-1 multipliers (source row, destination row, window area).
// Reset: arst_n clears the blit state (idle), the queue and the pipeline
//   valids; fb_base resets to 0, fb_width to 640. No clearing pass.
// Stalls: a two-word queue separates the front end from the back end; the
//   back end holds its output register while rsp.ready is low and keeps
//   taking words while its stage-1 or output slot is free.
// cfg is always ready; writes are expected only while the unit is idle.
module rect_blit_format_expand_unit #(
	parameter int MAX_DIM = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	rbfe_cfg_if.sink   cfg,
	rbfe_in_if.sink    req,
	rbfe_out_if.source rsp
);
	import rbfe_pkg::*;

	rbfe_cfg_t cfg_q;

	logic      f_valid, f_ready;
	rbfe_job_t f_job;
	logic      b_valid, b_ready;
	rbfe_job_t b_job;

	// Configuration registers: base address and destination stride
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fb_base  <= '0;
			cfg_q.fb_width <= FB_WIDTH_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_FB_BASE:  cfg_q.fb_base  <= cfg.data;
				CFG_FB_WIDTH: cfg_q.fb_width <= cfg.data[12:0];
				default: ;
			endcase
		end
	end

	// Front end: clipping, raster walk, pixel widening
	rbfe_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.job_valid (f_valid),
		.job_ready (f_ready),
		.job       (f_job)
	);

	// Decoupling queue
	rbfe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_job   (f_job),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_job    (b_job)
	);

	// Back end: addresses, source offsets, totals
	rbfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_regs  (cfg_q),
		.job_valid (b_valid),
		.job_ready (b_ready),
		.job       (b_job),
		.rsp       (rsp)
	);

endmodule
